/* rtl/core/qbf_pkg.sv */
// Shared types and constants for the quadratic Bezier flattener.
// Depends on nothing; imported by qbf_ctrl, qbf_datapath and the top level.
package qbf_pkg;

    localparam int THR_W = 8;
    localparam logic [THR_W-1:0] THR_RESET = 8'd5;
    localparam int APB_DW = 32;
    localparam int APB_AW = 2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic split;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic must_split;
        logic stack_empty;
    } status_t;

endpackage

/* rtl/core/qbf_ctrl.sv */
// Controller state machine of the flattener: input/output handshake and sequencing.
// Depends on qbf_pkg for the state, command and status types.
module qbf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  qbf_pkg::status_t status,
    output qbf_pkg::cmd_t    cmd
);
    import qbf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                cmd.split = status.must_split;
                cmd.emit  = !status.must_split && slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // the segment with an empty stack behind it ends the curve
                if (cmd.emit && status.stack_empty)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/qbf_datapath.sv */
// Datapath of the flattener: current half curve, split and flatness unit,
// pending stack of right halves and the output word register. Uses qbf_pkg.
module qbf_datapath #(
    parameter int MAX_DEPTH  = 5,
    parameter int COORD_BITS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qbf_pkg::cmd_t            cmd,
    output qbf_pkg::status_t         status,
    input  logic [qbf_pkg::THR_W-1:0] flat_threshold,
    input  logic [COORD_BITS-1:0]    start_x,
    input  logic [COORD_BITS-1:0]    start_y,
    input  logic [COORD_BITS-1:0]    ctrl_x,
    input  logic [COORD_BITS-1:0]    ctrl_y,
    input  logic [COORD_BITS-1:0]    end_x,
    input  logic [COORD_BITS-1:0]    end_y,
    output logic [COORD_BITS-1:0]    seg_x0,
    output logic [COORD_BITS-1:0]    seg_y0,
    output logic [COORD_BITS-1:0]    seg_x1,
    output logic [COORD_BITS-1:0]    seg_y1,
    output logic                     last_segment
);
    import qbf_pkg::*;

    localparam int CW       = COORD_BITS;
    localparam int STK_N    = MAX_DEPTH + 1;
    localparam int IDX_W    = $clog2(STK_N);
    localparam int SP_W     = $clog2(STK_N + 1);
    localparam int LVL_W    = $clog2(MAX_DEPTH + 2);
    localparam int DEV_W    = (CW + 1 > THR_W) ? CW + 1 : THR_W;
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_DEPTH);

    function automatic logic [CW-1:0] avg(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW:1];
    endfunction

    function automatic logic [CW-1:0] adiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // current half curve: points 0, 1 (control), 2
    logic [2:0][CW-1:0] px_reg;
    logic [2:0][CW-1:0] py_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [SP_W-1:0]    sp_reg;

    logic [2:0][CW-1:0] stk_x_reg [STK_N];
    logic [2:0][CW-1:0] stk_y_reg [STK_N];
    logic [LVL_W-1:0]   stk_l_reg [STK_N];

    logic [CW-1:0] seg_x0_reg;
    logic [CW-1:0] seg_y0_reg;
    logic [CW-1:0] seg_x1_reg;
    logic [CW-1:0] seg_y1_reg;
    logic          last_reg;

    logic [CW-1:0]    ax, ay, bx, by, qx, qy, mx, my;
    logic [CW:0]      dev;
    logic [DEV_W-1:0] dev_ext;
    logic [DEV_W-1:0] thr_ext;
    logic [SP_W-1:0]  sp_dec;
    logic [IDX_W-1:0] push_idx;
    logic [IDX_W-1:0] pop_idx;

    // de Casteljau midpoints
    assign ax = avg(px_reg[0], px_reg[1]);
    assign ay = avg(py_reg[0], py_reg[1]);
    assign qx = avg(px_reg[1], px_reg[2]);
    assign qy = avg(py_reg[1], py_reg[2]);
    assign bx = avg(ax, qx);
    assign by = avg(ay, qy);

    // Manhattan deviation of control point from the chord midpoint
    assign mx      = avg(px_reg[0], px_reg[2]);
    assign my      = avg(py_reg[0], py_reg[2]);
    assign dev     = {1'b0, adiff(px_reg[1], mx)} + {1'b0, adiff(py_reg[1], my)};
    assign dev_ext = DEV_W'(dev);
    assign thr_ext = DEV_W'(flat_threshold);

    assign status.must_split  = (lvl_reg == '0) || ((lvl_reg <= LVL_MAX) && (dev_ext > thr_ext));
    assign status.stack_empty = (sp_reg == '0);

    assign sp_dec   = sp_reg - SP_W'(1);
    assign push_idx = sp_reg[IDX_W-1:0];
    assign pop_idx  = sp_dec[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_reg <= '0;
        else if (cmd.load)
            sp_reg <= '0;
        else if (cmd.split)
            sp_reg <= sp_reg + SP_W'(1);
        else if (cmd.emit && !status.stack_empty)
            sp_reg <= sp_dec;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg  <= {end_x, ctrl_x, start_x};
            py_reg  <= {end_y, ctrl_y, start_y};
            lvl_reg <= '0;
        end
        else if (cmd.split)
        begin
            // keep the left half, push the right half
            px_reg  <= {bx, ax, px_reg[0]};
            py_reg  <= {by, ay, py_reg[0]};
            lvl_reg <= lvl_reg + LVL_W'(1);
        end
        else if (cmd.emit && !status.stack_empty)
        begin
            px_reg  <= stk_x_reg[pop_idx];
            py_reg  <= stk_y_reg[pop_idx];
            lvl_reg <= stk_l_reg[pop_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.split)
        begin
            stk_x_reg[push_idx] <= {px_reg[2], qx, bx};
            stk_y_reg[push_idx] <= {py_reg[2], qy, by};
            stk_l_reg[push_idx] <= lvl_reg + LVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            seg_x0_reg <= px_reg[0];
            seg_y0_reg <= py_reg[0];
            seg_x1_reg <= px_reg[2];
            seg_y1_reg <= py_reg[2];
            last_reg   <= status.stack_empty;
        end
    end

    assign seg_x0       = seg_x0_reg;
    assign seg_y0       = seg_y0_reg;
    assign seg_x1       = seg_x1_reg;
    assign seg_y1       = seg_y1_reg;
    assign last_segment = last_reg;

endmodule

/* rtl/core/quadratic_bezier_flattener_unit.sv */
// Top level of the quadratic Bezier flattener: APB register, controller and datapath.
// Depends on qbf_pkg, qbf_ctrl and qbf_datapath.
//
// Usage: one input word is a curve (start, control, end point). The block
// splits it by midpoint subdivision and returns its segments in curve order,
// one output word per segment, with last_segment set on the final one.
// A curve yields 2 to 2^(MAX_DEPTH+1) segments.
// Timing: once the curve is taken, the shared split and flatness unit
// handles one half curve per cycle, either splitting it or emitting it as
// a segment; an emission waits while the output register is full and not
// taken. The first segment shows up after the initial descent.
// The next curve is taken once the final segment sits in the output
// register, even if it has not yet been taken.
// Stall: a full output register that is not taken holds back emission;
// splitting goes on and nothing is dropped.
// Reset: the controller goes idle, the output is empty and flat_threshold
// returns to 5. flat_threshold is written through APB; paddr is not decoded.
module quadratic_bezier_flattener_unit #(
    parameter int MAX_DEPTH  = 5,
    parameter int COORD_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qbf_pkg::APB_AW-1:0] paddr,
    input  logic [qbf_pkg::APB_DW-1:0] pwdata,
    output logic [qbf_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [COORD_BITS-1:0]      start_x,
    input  logic [COORD_BITS-1:0]      start_y,
    input  logic [COORD_BITS-1:0]      ctrl_x,
    input  logic [COORD_BITS-1:0]      ctrl_y,
    input  logic [COORD_BITS-1:0]      end_x,
    input  logic [COORD_BITS-1:0]      end_y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [COORD_BITS-1:0]      seg_x0,
    output logic [COORD_BITS-1:0]      seg_y0,
    output logic [COORD_BITS-1:0]      seg_x1,
    output logic [COORD_BITS-1:0]      seg_y1,
    output logic                       last_segment
);
    import qbf_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             apb_wr;
    cmd_t             cmd;
    status_t          status;

    // single register; every address decodes to it
    assign apb_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = APB_DW'(thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (apb_wr)
            thr_reg <= pwdata[THR_W-1:0];
    end

    qbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    qbf_datapath #(
        .MAX_DEPTH  (MAX_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .flat_threshold (thr_reg),
        .start_x        (start_x),
        .start_y        (start_y),
        .ctrl_x         (ctrl_x),
        .ctrl_y         (ctrl_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .seg_x0         (seg_x0),
        .seg_y0         (seg_y0),
        .seg_x1         (seg_x1),
        .seg_y1         (seg_y1),
        .last_segment   (last_segment)
    );

endmodule

/* rtl/core/qbf_checker.sv */
// Port-level assertions for the flattener, bound to the top level.
// Depends on quadratic_bezier_flattener_unit port names only.
module qbf_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COORD_BITS-1:0] seg_x0,
    input logic [COORD_BITS-1:0] seg_y0,
    input logic [COORD_BITS-1:0] seg_x1,
    input logic [COORD_BITS-1:0] seg_y1,
    input logic                  last_segment
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(seg_x0) && $stable(seg_y0)
            && $stable(seg_x1) && $stable(seg_y1) && $stable(last_segment))
        else $error("output word changed while stalled");

    // a taken curve makes the input not ready in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after accepting a curve");

    // a curve is not done until its last segment has been produced
    a_busy_mid_curve: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_segment |=> !in_ready || (out_valid && last_segment))
        else $error("input ready while a curve is still being flattened");

    // when idle, any waiting word must be the final segment of a curve
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last_segment)
        else $error("idle with a non-final segment pending");

endmodule

bind quadratic_bezier_flattener_unit qbf_checker #(
    .COORD_BITS (COORD_BITS)
) u_qbf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .seg_x0       (seg_x0),
    .seg_y0       (seg_y0),
    .seg_x1       (seg_x1),
    .seg_y1       (seg_y1),
    .last_segment (last_segment)
);

/* verif/tb_quadratic_bezier_flattener_unit.sv */
// Self-checking bench for quadratic_bezier_flattener_unit: curves go in, segments come out.
// Depends on qbf_pkg and the flattener RTL; expected segments come from an in-bench
// midpoint subdivision predictor kept in a small scoreboard class.
module tb_quadratic_bezier_flattener_unit;
    import qbf_pkg::*;

    localparam int MAX_DEPTH = 5;
    localparam int CW = 10;
    localparam int LIMIT = 1_000_000;
    localparam logic [APB_AW-1:0] REG_FLAT_THRESHOLD = '0;

    typedef struct {
        logic [CW-1:0] x[3];
        logic [CW-1:0] y[3];
        int unsigned   depth;
    } bez_t;

    typedef struct packed {
        logic [CW-1:0] x0;
        logic [CW-1:0] y0;
        logic [CW-1:0] x1;
        logic [CW-1:0] y1;
        logic          last;
    } seg_t;

    class seg_ledger;
        seg_t             expected_segs[$];
        logic [THR_W-1:0] threshold;
        int               errors;
        int               checked;
        int               widest;

        function new();
            threshold = THR_RESET;
            errors = 0;
            checked = 0;
            widest = 0;
        endfunction

        function int pending();
            return expected_segs.size();
        endfunction

        function logic [CW-1:0] mid(logic [CW-1:0] a, logic [CW-1:0] b);
            logic [CW:0] s;
            s = a + b;
            return s[CW:1];
        endfunction

        function int gap(logic [CW-1:0] a, logic [CW-1:0] b);
            return (a > b) ? int'(a - b) : int'(b - a);
        endfunction

        function bit too_curved(bez_t c);
            int dev;
            dev = gap(c.x[1], mid(c.x[0], c.x[2])) + gap(c.y[1], mid(c.y[0], c.y[2]));
            return dev > int'(threshold);
        endfunction

        function void halve(input bez_t c, output bez_t lo, output bez_t hi);
            logic [CW-1:0] ax, ay, cx, cy, bx, by;
            ax = mid(c.x[0], c.x[1]);
            ay = mid(c.y[0], c.y[1]);
            cx = mid(c.x[1], c.x[2]);
            cy = mid(c.y[1], c.y[2]);
            bx = mid(ax, cx);
            by = mid(ay, cy);
            lo.x = '{c.x[0], ax, bx};
            lo.y = '{c.y[0], ay, by};
            lo.depth = c.depth + 1;
            hi.x = '{bx, cx, c.x[2]};
            hi.y = '{by, cy, c.y[2]};
            hi.depth = c.depth + 1;
        endfunction

        // Flatten one accepted curve, left half first, and queue its segments.
        function void note_curve(bez_t c);
            bez_t pend[$];
            bez_t cur, lo, hi;
            seg_t segs[$];
            seg_t s;
            cur = c;
            cur.depth = 0;
            // the whole curve is split once without a flatness test
            halve(cur, lo, hi);
            pend.push_back(hi);
            cur = lo;
            forever begin
                if (cur.depth <= MAX_DEPTH && too_curved(cur) && pend.size() <= MAX_DEPTH) begin
                    halve(cur, lo, hi);
                    pend.push_back(hi);
                    cur = lo;
                end
                else begin
                    s.x0 = cur.x[0];
                    s.y0 = cur.y[0];
                    s.x1 = cur.x[2];
                    s.y1 = cur.y[2];
                    s.last = 1'b0;
                    segs.push_back(s);
                    if (pend.size() == 0)
                        break;
                    cur = pend.pop_back();
                end
            end
            segs[segs.size()-1].last = 1'b1;
            if (segs.size() > widest)
                widest = segs.size();
            expected_segs = {expected_segs, segs};
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 100)
                $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string field, logic [CW-1:0] got, logic [CW-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("segment %0d %s: got %0d, expected %0d",
                                          checked, field, got, want));
        endtask

        task check_segment(seg_t got);
            seg_t want;
            if (expected_segs.size() == 0) begin
                report_mismatch($sformatf("unexpected segment (%0d,%0d)-(%0d,%0d)",
                                          got.x0, got.y0, got.x1, got.y1));
                return;
            end
            want = expected_segs.pop_front();
            checked++;
            compare_field("seg_x0", got.x0, want.x0);
            compare_field("seg_y0", got.y0, want.y0);
            compare_field("seg_x1", got.x1, want.x1);
            compare_field("seg_y1", got.y1, want.y1);
            compare_field("last_segment", got.last, want.last);
        endtask

        task flag_leftovers();
            if (expected_segs.size() > 0)
                report_mismatch($sformatf("%0d expected segments never came",
                                          expected_segs.size()));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [CW-1:0]     start_x = '0;
    logic [CW-1:0]     start_y = '0;
    logic [CW-1:0]     ctrl_x = '0;
    logic [CW-1:0]     ctrl_y = '0;
    logic [CW-1:0]     end_x = '0;
    logic [CW-1:0]     end_y = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CW-1:0]     seg_x0;
    logic [CW-1:0]     seg_y0;
    logic [CW-1:0]     seg_x1;
    logic [CW-1:0]     seg_y1;
    logic              last_segment;

    bit        tx_calm = 1'b0;
    bit        rx_calm = 1'b0;
    int        sent = 0;
    int        settings = 0;
    seg_ledger ledger = new();

    quadratic_bezier_flattener_unit #(
        .MAX_DEPTH  (MAX_DEPTH),
        .COORD_BITS (CW)
    ) i_dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("Timed out after %0d cycles", LIMIT);
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            ledger.check_segment({seg_x0, seg_y0, seg_x1, seg_y1, last_segment});
    end

    // Segment side: stall a random number of cycles before each word.
    initial
    begin : rx_side
        int stall;
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    task automatic write_threshold(logic [THR_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_FLAT_THRESHOLD;
        pwdata <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        ledger.threshold = value;
        settings++;
    endtask

    task automatic send_curve(bez_t c);
        int wait_cycles;
        wait_cycles = tx_calm ? 0 : $urandom_range(0, 14);
        if (wait_cycles > 0) begin
            in_valid <= 1'b0;
            repeat (wait_cycles) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x <= c.x[0];
        start_y <= c.y[0];
        ctrl_x <= c.x[1];
        ctrl_y <= c.y[1];
        end_x <= c.x[2];
        end_y <= c.y[2];
        do @(posedge clk); while (in_ready !== 1'b1);
        ledger.note_curve(c);
        sent++;
    endtask

    task automatic send_pts(int sx, int sy, int cx, int cy, int ex, int ey);
        bez_t c;
        c.x = '{CW'(sx), CW'(cx), CW'(ex)};
        c.y = '{CW'(sy), CW'(cy), CW'(ey)};
        c.depth = 0;
        send_curve(c);
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
    endfunction

    function automatic bez_t random_curve();
        bez_t c;
        int   pick, span, bx, by, dev;
        pick = $urandom_range(0, 99);
        c.depth = 0;
        if (pick < 40) begin
            for (int i = 0; i < 3; i++) begin
                c.x[i] = CW'($urandom_range(0, 1023));
                c.y[i] = CW'($urandom_range(0, 1023));
            end
        end
        else if (pick < 75) begin
            // small box: few subdivision levels
            span = $urandom_range(1, 127);
            bx = $urandom_range(0, 1023 - span);
            by = $urandom_range(0, 1023 - span);
            for (int i = 0; i < 3; i++) begin
                c.x[i] = CW'(bx + $urandom_range(0, span));
                c.y[i] = CW'(by + $urandom_range(0, span));
            end
        end
        else begin
            // nearly straight: control point close to the chord midpoint
            dev = $urandom_range(0, 12);
            c.x[0] = CW'($urandom_range(0, 1023));
            c.y[0] = CW'($urandom_range(0, 1023));
            c.x[2] = CW'($urandom_range(0, 1023));
            c.y[2] = CW'($urandom_range(0, 1023));
            c.x[1] = CW'(clamp_coord((int'(c.x[0]) + int'(c.x[2])) / 2
                                     + $urandom_range(0, 2 * dev) - dev));
            c.y[1] = CW'(clamp_coord((int'(c.y[0]) + int'(c.y[2])) / 2
                                     + $urandom_range(0, 2 * dev) - dev));
        end
        return c;
    endfunction

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 12 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            send_curve(random_curve());
        end
    endtask

    // Hold off the sender until every expected segment is out, then rest.
    task automatic drain_then_rest(int rest);
        in_valid <= 1'b0;
        while (ledger.pending() > 0) @(posedge clk);
        repeat (rest) @(posedge clk);
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset threshold
        send_pts(0, 0, 0, 0, 0, 0);
        send_pts(1023, 1023, 1023, 1023, 1023, 1023);
        send_pts(700, 300, 700, 300, 700, 300);
        send_pts(0, 0, 511, 511, 1023, 1023);
        send_pts(0, 0, 1023, 0, 1023, 1023);
        send_pts(0, 0, 1023, 1023, 0, 0);
        send_pts(1023, 0, 0, 1023, 1023, 0);
        send_pts(0, 1023, 1023, 1023, 1023, 0);
        // halves land exactly on the threshold, then just above it
        send_pts(0, 0, 200, 20, 400, 0);
        send_pts(0, 0, 200, 22, 400, 0);
        send_pts('h2AA, 'h155, 'h155, 'h2AA, 'h2AA, 'h155);
        send_pts('h155, 'h2AA, 'h2AA, 'h155, 'h155, 'h2AA);
        drain_then_rest(8);

        // zero threshold: any bend splits, depth bound caps the count
        write_threshold('0);
        send_pts(0, 0, 0, 0, 0, 0);
        send_pts(0, 0, 200, 22, 400, 0);
        send_pts(0, 0, 1023, 1023, 0, 0);
        send_pts(0, 0, 511, 511, 1023, 1023);
        send_random(30);
        drain_then_rest(8);

        write_threshold('1);
        send_pts(0, 0, 1023, 1023, 0, 0);
        send_pts(0, 0, 1023, 0, 1023, 1023);
        send_random(30);
        drain_then_rest(8);

        for (int p = 0; p < 3; p++) begin
            write_threshold(THR_W'($urandom_range(1, 254)));
            send_random(35);
            drain_then_rest(8);
        end

        write_threshold(THR_RESET);
        send_random(25);
        drain_then_rest(8);
        send_random(30);

        in_valid <= 1'b0;
        for (int w = 0; w < 50000 && ledger.pending() > 0; w++) @(posedge clk);
        repeat (16) @(posedge clk);
        ledger.flag_leftovers();
        $display("Sent %0d curves under %0d threshold writes; %0d segments checked.",
                 sent, settings, ledger.checked);
        $display("Longest curve gave %0d segments; %0d mismatches.",
                 ledger.widest, ledger.errors);
        if (ledger.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
